// File: rtl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants for the xor-checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned POS_CAP  = 2039;
	localparam int unsigned ADDR_W   = 3;
	localparam int unsigned DATA_W   = 32;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h7e;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h7f;
	localparam logic [BYTE_W-1:0] VER_BYTE   = 8'h01;

	localparam logic [BYTE_W-1:0] SRC_BCAST  = 8'hff;
	localparam logic [BYTE_W-1:0] SRC_A      = 8'h30;
	localparam logic [BYTE_W-1:0] SRC_B      = 8'h31;
	localparam logic [BYTE_W-1:0] SRC_C      = 8'h32;
	localparam logic [BYTE_W-1:0] SRC_D      = 8'h10;

	localparam logic [BYTE_W-1:0] CMD_A      = 8'h10;
	localparam logic [BYTE_W-1:0] CMD_B      = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_C      = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_D      = 8'h05;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_LEN     = 2'd1;
	localparam logic [STAT_W-1:0] ST_TYPE    = 2'd2;
	localparam logic [STAT_W-1:0] ST_CSUM    = 2'd3;

	localparam logic [POS_W-1:0] POS_SRC     = 11'd1;
	localparam logic [POS_W-1:0] POS_VER     = 11'd2;
	localparam logic [POS_W-1:0] POS_CMD     = 11'd3;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 11'd5;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 11'd6;

	localparam logic [0:0] REG_MAX_LEN       = 1'b0;
	localparam logic [POS_W-1:0] MAX_LEN_RST = 11'd1024;

	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_HEAD = 5'b00010,
		PH_PAY  = 5'b00100,
		PH_CHK  = 5'b01000,
		PH_END  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] frame_byte;
		logic [POS_W-1:0]  byte_pos;
		logic              frame_last;
		logic [STAT_W-1:0] frame_status;
	} result_t;

	function automatic logic source_ok(input logic [BYTE_W-1:0] b);
		return (b == SRC_BCAST) || (b == SRC_A) || (b == SRC_B) || (b == SRC_C) ||
			(b == SRC_D);
	endfunction

	function automatic logic command_ok(input logic [BYTE_W-1:0] b);
		return (b == CMD_A) || (b == CMD_B) || (b == CMD_C) || (b == CMD_D);
	endfunction

endpackage

// File: rtl/xcfr_apb_regs.sv
// ----------------------------------------------------------------------------
// xcfr_apb_regs
// APB register block holding the payload length limit.
// ----------------------------------------------------------------------------
module xcfr_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xcfr_pkg::ADDR_W-1:0] paddr,
	input  logic [xcfr_pkg::DATA_W-1:0] pwdata,
	output logic [xcfr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic [xcfr_pkg::POS_W-1:0]  max_len
);
	import xcfr_pkg::*;

	logic [POS_W-1:0] max_len_q;
	logic             sel_max;

	assign sel_max = (paddr[ADDR_W-1] == REG_MAX_LEN);
	assign pready  = 1'b1;
	assign max_len = max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (psel && penable && pwrite && sel_max) begin
			max_len_q <= pwdata[POS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_max) begin
			prdata = {{(DATA_W-POS_W){1'b0}}, max_len_q};
		end
	end

endmodule

// File: rtl/xcfr_parse_core.sv
// ----------------------------------------------------------------------------
// xcfr_parse_core
// Frame state and per-byte decode: hunt, header checks, payload count,
// checksum compare and end-byte status.
// ----------------------------------------------------------------------------
module xcfr_parse_core #(
	parameter int unsigned LEN_LIMIT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [xcfr_pkg::BYTE_W-1:0] rx,
	input  logic [xcfr_pkg::POS_W-1:0]  max_len,
	output xcfr_pkg::result_t           res
);
	import xcfr_pkg::*;

	localparam int unsigned CAP_I = (LEN_LIMIT < POS_CAP) ? LEN_LIMIT : POS_CAP;
	localparam logic [POS_W-1:0] CAP = CAP_I[POS_W-1:0];

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d, pos_inc;
	logic [LEN_W-1:0]  len_q, len_d, len_full;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic              type_ok_q, type_ok_d;
	logic              csum_ok_q, csum_ok_d;
	logic [POS_W-1:0]  eff_lim;
	logic [LEN_W:0]    pay_end;

	assign eff_lim  = (max_len > CAP) ? CAP : max_len;
	assign pos_inc  = pos_q + 1'b1;
	assign len_full = {len_q[LEN_W-1:BYTE_W], rx};
	assign pay_end  = {1'b0, len_q} + (LEN_W+1)'(POS_LEN_LO);

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		len_d     = len_q;
		xor_d     = xor_q;
		type_ok_d = type_ok_q;
		csum_ok_d = csum_ok_q;
		res       = '0;
		res.frame_byte = rx;
		case (phase_q)
			PH_HEAD: begin
				res.valid = 1'b1;
				res.byte_pos = pos_inc;
				pos_d = pos_inc;
				xor_d = xor_q ^ rx;
				if (pos_inc == POS_SRC && !source_ok(rx)) begin
					type_ok_d = 1'b0;
				end
				if (pos_inc == POS_VER && rx != VER_BYTE) begin
					type_ok_d = 1'b0;
				end
				if (pos_inc == POS_CMD && !command_ok(rx)) begin
					type_ok_d = 1'b0;
				end
				if (pos_inc == POS_LEN_HI) begin
					len_d = {rx, {BYTE_W{1'b0}}};
				end
				if (pos_inc == POS_LEN_LO) begin
					len_d = len_full;
					if (len_full > {{(LEN_W-POS_W){1'b0}}, eff_lim}) begin
						res.frame_last   = 1'b1;
						res.frame_status = ST_LEN;
						phase_d = PH_HUNT;
					end else if (len_full == '0) begin
						phase_d = PH_CHK;
					end else begin
						phase_d = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				res.valid = 1'b1;
				res.byte_pos = pos_inc;
				pos_d = pos_inc;
				xor_d = xor_q ^ rx;
				if ({{(LEN_W+1-POS_W){1'b0}}, pos_inc} >= pay_end) begin
					phase_d = PH_CHK;
				end
			end
			PH_CHK: begin
				res.valid = 1'b1;
				res.byte_pos = pos_inc;
				pos_d = pos_inc;
				csum_ok_d = (rx == xor_q);
				xor_d = xor_q ^ rx;
				phase_d = PH_END;
			end
			PH_END: begin
				res.valid = 1'b1;
				res.byte_pos = pos_inc;
				res.frame_last = 1'b1;
				pos_d = pos_inc;
				if (rx != END_BYTE) begin
					res.frame_status = ST_LEN;
				end else if (!type_ok_q) begin
					res.frame_status = ST_TYPE;
				end else if (!csum_ok_q) begin
					res.frame_status = ST_CSUM;
				end else begin
					res.frame_status = ST_OK;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx == START_BYTE) begin
					res.valid = 1'b1;
					phase_d   = PH_HEAD;
					pos_d     = '0;
					len_d     = '0;
					xor_d     = rx;
					type_ok_d = 1'b1;
					csum_ok_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			pos_q     <= '0;
			len_q     <= '0;
			xor_q     <= '0;
			type_ok_q <= 1'b1;
			csum_ok_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			len_q     <= len_d;
			xor_q     <= xor_d;
			type_ok_q <= type_ok_d;
			csum_ok_q <= csum_ok_d;
		end
	end

endmodule

// File: rtl/xor_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Receives serial bytes, finds framed requests and echoes each frame byte
// with its position, a last flag and a status on the last byte.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle when the output side keeps up. A byte
// goes into an input register and is decoded against the frame state from
// there. The result is loaded into the output register when that register is
// free or its result is being taken. Bytes outside a frame give no result, but
// they still wait for the output register to be free. The output register and
// the input register each hold one byte. While a result waits to be taken, the
// input takes one more byte and then stalls until the result goes.
module xor_checked_frame_receiver #(
	parameter int unsigned LEN_LIMIT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xcfr_pkg::ADDR_W-1:0] paddr,
	input  logic [xcfr_pkg::DATA_W-1:0] pwdata,
	output logic [xcfr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [xcfr_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [xcfr_pkg::BYTE_W-1:0] frame_byte,
	output logic [xcfr_pkg::POS_W-1:0]  byte_pos,
	output logic                        frame_last,
	output logic [xcfr_pkg::STAT_W-1:0] frame_status
);
	import xcfr_pkg::*;

	logic [POS_W-1:0]  max_len;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	result_t           res;
	result_t           res_s2;

	xcfr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_len (max_len)
	);

	assign advance  = valid_s1 && (!res_s2.valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	xcfr_parse_core #(
		.LEN_LIMIT (LEN_LIMIT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx      (byte_s1),
		.max_len (max_len),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			res_s2 <= res;
		end else if (out_ready) begin
			res_s2.valid <= 1'b0;
		end
	end

	assign out_valid    = res_s2.valid;
	assign frame_byte   = res_s2.frame_byte;
	assign byte_pos     = res_s2.byte_pos;
	assign frame_last   = res_s2.frame_last;
	assign frame_status = res_s2.frame_status;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_status_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_last |-> frame_status == ST_OK)
		else $error("status set on a byte that does not end the frame");

	a_start_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_pos == '0 |-> frame_byte == START_BYTE && !frame_last)
		else $error("frame opened by a byte other than the start byte");

	a_len_abort_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last && byte_pos == POS_LEN_LO |-> frame_status == ST_LEN)
		else $error("abort on the length byte without length status");

endmodule

// File: tb/xor_checked_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_tb
// Self-checking testbench for the xor-checked frame receiver. Byte requests go
// in through the valid/ready input, and a local frame tracker predicts the echo
// of each accepted frame byte: its position, the last flag and the frame status. The
// echoes that come out are compared in order against the predicted ones. The
// run covers directed frames for every status, the length limit and resync,
// and then random framed traffic with noise over several length-limit
// settings. Both sides idle at random.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_tb;
	import xcfr_pkg::*;

	localparam int unsigned LEN_LIMIT = 1024;
	localparam logic [ADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR   = {~REG_MAX_LEN, 2'b00};

	typedef struct packed {
		logic [BYTE_W-1:0] fbyte;
		logic [POS_W-1:0]  pos;
		logic              last;
		logic [STAT_W-1:0] status;
	} echo_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [BYTE_W-1:0]   rx_byte;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BYTE_W-1:0]   frame_byte;
	logic [POS_W-1:0]    byte_pos;
	logic                frame_last;
	logic [STAT_W-1:0]   frame_status;

	echo_t               echo_due[$];
	logic [BYTE_W-1:0]   pay_buf[$];
	logic [BYTE_W-1:0]   src_list[5] = '{SRC_BCAST, SRC_A, SRC_B, SRC_C, SRC_D};
	logic [BYTE_W-1:0]   cmd_list[4] = '{CMD_A, CMD_B, CMD_C, CMD_D};
	int                  mismatches = 0;
	int                  frame_bytes = 0;
	logic                steady = 1'b0;

	// frame tracker state
	phase_t              rx_ph = PH_HUNT;
	logic [POS_W-1:0]    pos_cnt = '0;
	logic [LEN_W-1:0]    pay_len = '0;
	logic [BYTE_W-1:0]   xor_acc = '0;
	logic                hdr_ok = 1'b1;
	logic                csum_ok = 1'b0;
	logic [POS_W-1:0]    len_reg = MAX_LEN_RST;

	xor_checked_frame_receiver #(.LEN_LIMIT(LEN_LIMIT)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready), .frame_byte(frame_byte),
		.byte_pos(byte_pos), .frame_last(frame_last), .frame_status(frame_status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 31);
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 31);
	endfunction

	function automatic bit src_valid(input logic [BYTE_W-1:0] b);
		return b == SRC_BCAST || b == SRC_A || b == SRC_B || b == SRC_C || b == SRC_D;
	endfunction

	function automatic bit cmd_valid(input logic [BYTE_W-1:0] b);
		return b == CMD_A || b == CMD_B || b == CMD_C || b == CMD_D;
	endfunction

	function automatic int len_cap();
		int c;
		c = len_reg;
		if (c > LEN_LIMIT) c = LEN_LIMIT;
		if (c > POS_CAP) c = POS_CAP;
		return c;
	endfunction

	task automatic predict_echo(input logic [BYTE_W-1:0] b);
		echo_t e;
		logic [POS_W-1:0] p;
		if (rx_ph == PH_HUNT) begin
			if (b == START_BYTE) begin
				hdr_ok = 1'b1;
				csum_ok = 1'b0;
				pay_len = '0;
				xor_acc = b;
				pos_cnt = '0;
				rx_ph = PH_HEAD;
				e = '{fbyte: b, pos: '0, last: 1'b0, status: ST_OK};
				echo_due.push_back(e);
			end
		end else begin
			p = pos_cnt + 1'b1;
			pos_cnt = p;
			e = '{fbyte: b, pos: p, last: 1'b0, status: ST_OK};
			case (rx_ph)
				PH_HEAD: begin
					if (p == POS_SRC && !src_valid(b)) hdr_ok = 1'b0;
					if (p == POS_VER && b != VER_BYTE) hdr_ok = 1'b0;
					if (p == POS_CMD && !cmd_valid(b)) hdr_ok = 1'b0;
					if (p == POS_LEN_HI) pay_len = {b, 8'h00};
					if (p == POS_LEN_LO) begin
						pay_len = {pay_len[15:8], b};
						if (int'(pay_len) > len_cap()) begin
							e.last = 1'b1;
							e.status = ST_LEN;
							rx_ph = PH_HUNT;
						end else begin
							rx_ph = (pay_len == 0) ? PH_CHK : PH_PAY;
						end
					end
					xor_acc ^= b;
				end
				PH_PAY: begin
					xor_acc ^= b;
					if (int'(p) >= 6 + int'(pay_len)) rx_ph = PH_CHK;
				end
				PH_CHK: begin
					csum_ok = (b == xor_acc);
					xor_acc ^= b;
					rx_ph = PH_END;
				end
				default: begin
					e.last = 1'b1;
					if (b != END_BYTE) e.status = ST_LEN;
					else if (!hdr_ok) e.status = ST_TYPE;
					else if (!csum_ok) e.status = ST_CSUM;
					else e.status = ST_OK;
					rx_ph = PH_HUNT;
				end
			endcase
			echo_due.push_back(e);
		end
	endtask

	always @(posedge clk) begin
		echo_t e;
		if (arst_n && out_valid && out_ready) begin
			if (echo_due.size() == 0) begin
				$display("%0t unexpected echo: expected none, got byte %h pos %0d last %b status %0d",
					$time, frame_byte, byte_pos, frame_last, frame_status);
				mismatches++;
			end else begin
				e = echo_due.pop_front();
				if (frame_byte !== e.fbyte) begin
					$display("%0t frame_byte: expected %h, got %h", $time, e.fbyte, frame_byte);
					mismatches++;
				end
				if (byte_pos !== e.pos) begin
					$display("%0t byte_pos: expected %0d, got %0d", $time, e.pos, byte_pos);
					mismatches++;
				end
				if (frame_last !== e.last) begin
					$display("%0t frame_last: expected %b, got %b", $time, e.last, frame_last);
					mismatches++;
				end
				if (frame_status !== e.status) begin
					$display("%0t frame_status: expected %0d, got %0d", $time, e.status,
						frame_status);
					mismatches++;
				end
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_echo(b);
	endtask

	// stops after the length bytes when the length is over the limit
	task automatic send_frame(input logic [BYTE_W-1:0] src, input logic [BYTE_W-1:0] ver,
			input logic [BYTE_W-1:0] cmd, input logic [LEN_W-1:0] len_field,
			input logic [BYTE_W-1:0] csum_flip, input logic [BYTE_W-1:0] end_b);
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] spare;
		int cap;
		cap = len_cap();
		spare = 8'($urandom);
		acc = START_BYTE ^ src ^ ver ^ cmd ^ spare ^ len_field[15:8] ^ len_field[7:0];
		send_byte(START_BYTE);
		send_byte(src);
		send_byte(ver);
		send_byte(cmd);
		send_byte(spare);
		send_byte(len_field[15:8]);
		send_byte(len_field[7:0]);
		if (int'(len_field) <= cap) begin
			foreach (pay_buf[i]) begin
				send_byte(pay_buf[i]);
				acc ^= pay_buf[i];
			end
			send_byte(acc ^ csum_flip);
			send_byte(end_b);
		end
		frame_bytes += 9 + pay_buf.size();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (echo_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [POS_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (a == MAX_LEN_ADDR) len_reg = v;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] a, input logic [POS_W-1:0] exp_v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[POS_W-1:0] !== exp_v) begin
			$display("%0t max_payload_len read: expected %0d, got %0d", $time, exp_v,
				prdata[POS_W-1:0]);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_register_access();
		apb_read(MAX_LEN_ADDR, MAX_LEN_RST);
		apb_write(SPARE_ADDR, 11'd5);
		apb_read(MAX_LEN_ADDR, MAX_LEN_RST);
		apb_write(MAX_LEN_ADDR, 11'd0);
		apb_read(MAX_LEN_ADDR, 11'd0);
		apb_write(MAX_LEN_ADDR, MAX_LEN_RST);
		apb_read(MAX_LEN_ADDR, MAX_LEN_RST);
	endtask

	task automatic test_clean_frames();
		// bytes outside a frame
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(END_BYTE);
		send_byte(VER_BYTE);
		pay_buf.delete();
		send_frame(SRC_BCAST, VER_BYTE, CMD_A, 16'd0, 8'h00, END_BYTE);
		// start byte and extremes inside the payload
		pay_buf = '{START_BYTE, 8'h00, 8'hff};
		send_frame(SRC_A, VER_BYTE, CMD_B, 16'd3, 8'h00, END_BYTE);
		pay_buf = '{8'h55};
		send_frame(SRC_B, VER_BYTE, CMD_C, 16'd1, 8'h00, END_BYTE);
		send_frame(SRC_C, VER_BYTE, CMD_D, 16'd1, 8'h00, END_BYTE);
		send_frame(SRC_D, VER_BYTE, CMD_A, 16'd1, 8'h00, END_BYTE);
	endtask

	task automatic test_status_priority();
		pay_buf.delete();
		send_frame(SRC_A, 8'h02, 8'h77, 16'd0, 8'h01, 8'h00);
		send_frame(SRC_B, 8'h02, CMD_A, 16'd0, 8'h80, END_BYTE);
		pay_buf = '{8'haa, 8'h7f};
		send_frame(8'h00, VER_BYTE, CMD_B, 16'd2, 8'h00, END_BYTE);
		send_frame(SRC_C, VER_BYTE, 8'hff, 16'd2, 8'h00, END_BYTE);
		send_frame(SRC_D, VER_BYTE, CMD_C, 16'd2, 8'h01, END_BYTE);
	endtask

	task automatic test_length_limit();
		wait_idle();
		apb_write(MAX_LEN_ADDR, 11'd0);
		pay_buf.delete();
		// abort, then resync on the very next byte
		send_frame(SRC_A, VER_BYTE, CMD_A, 16'd1, 8'h00, END_BYTE);
		send_frame(SRC_A, VER_BYTE, CMD_B, 16'd0, 8'h00, END_BYTE);
		wait_idle();
		apb_write(MAX_LEN_ADDR, MAX_LEN_RST);
		send_frame(SRC_B, VER_BYTE, CMD_C, 16'h0401, 8'h00, END_BYTE);
		send_frame(SRC_C, VER_BYTE, CMD_D, 16'hffff, 8'h00, END_BYTE);
		// register above the parameter bound
		wait_idle();
		apb_write(MAX_LEN_ADDR, 11'h7ff);
		send_frame(SRC_D, VER_BYTE, CMD_B, 16'(LEN_LIMIT + 1), 8'h00, END_BYTE);
		send_frame(SRC_D, VER_BYTE, CMD_B, 16'h07f8, 8'h00, END_BYTE);
		pay_buf = '{8'h12, 8'h34};
		send_frame(SRC_BCAST, VER_BYTE, CMD_A, 16'd2, 8'h00, END_BYTE);
	endtask

	task automatic test_random_traffic();
		logic [POS_W-1:0] lim;
		logic [BYTE_W-1:0] src, ver, cmd, flip, end_b;
		logic [LEN_W-1:0] len;
		int cap, top, start, r;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = MAX_LEN_RST;
				1: lim = 11'd0;
				3: lim = 11'd1;
				5: lim = MAX_LEN_RST;
				default: lim = 11'($urandom_range(2, LEN_LIMIT));
			endcase
			wait_idle();
			apb_write(MAX_LEN_ADDR, lim);
			apb_read(MAX_LEN_ADDR, lim);
			steady <= (ph == 2);
			cap = len_cap();
			start = frame_bytes;
			while (frame_bytes - start < 160) begin
				if ($urandom_range(1) == 0) begin
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
				end
				if ($urandom_range(39) == 0) wait_idle();
				src = ($urandom_range(99) < 85) ? src_list[$urandom_range(4)] : 8'($urandom);
				ver = ($urandom_range(99) < 90) ? VER_BYTE : 8'($urandom);
				cmd = ($urandom_range(99) < 85) ? cmd_list[$urandom_range(3)] : 8'($urandom);
				flip = ($urandom_range(99) < 90) ? 8'h00 : 8'($urandom_range(1, 255));
				end_b = ($urandom_range(99) < 92) ? END_BYTE : 8'($urandom);
				r = $urandom_range(99);
				top = (cap < 16) ? cap : 16;
				if (r < 6) begin
					len = ($urandom_range(1) == 0) ? 16'(cap + 1 + $urandom_range(3))
						: 16'($urandom);
					if (int'(len) <= cap) len = 16'(cap + 1);
				end else if (r < 9 && cap <= 64) begin
					len = 16'(cap);
				end else begin
					len = 16'($urandom_range(0, top));
				end
				pay_buf.delete();
				if (int'(len) <= cap) repeat (len) pay_buf.push_back(8'($urandom));
				send_frame(src, ver, cmd, len, flip, end_b);
			end
		end
		steady <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_clean_frames();
		test_status_priority();
		test_length_limit();
		test_random_traffic();

		in_valid <= 1'b0;
		guard = 0;
		while (echo_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (echo_due.size() != 0) begin
			$display("%0t echoes missing: expected %0d more, got none", $time,
				echo_due.size());
			mismatches++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/xcfr_pkg.sv
rtl/xcfr_apb_regs.sv
rtl/xcfr_parse_core.sv
rtl/xor_checked_frame_receiver.sv
tb/xor_checked_frame_receiver_tb.sv
